/* rtl/dccp_pkg.sv */
// ----------------------------------------------------------------------------
// dccp_pkg
// Types, character codes and helpers shared by the change command parser,
// its channel interfaces and its checker.
// ----------------------------------------------------------------------------
package dccp_pkg;

   // Width of the internal line number accumulators (saturating).
   localparam int NUM_WIDTH = 32;
   // Width of the line number fields of a result item.
   localparam int OUT_WIDTH = 32;
   localparam int CH_WIDTH  = 8;

   typedef logic [NUM_WIDTH-1:0] num_type;
   typedef logic [OUT_WIDTH-1:0] out_num_type;
   typedef logic [CH_WIDTH-1:0]  char_type;

   // Character codes used by the grammar.
   localparam char_type CH_NUL   = 8'h00;
   localparam char_type CH_TAB   = 8'h09;
   localparam char_type CH_SPACE = 8'h20;
   localparam char_type CH_COMMA = 8'h2C;
   localparam char_type CH_ZERO  = 8'h30;
   localparam char_type CH_NINE  = 8'h39;
   localparam char_type CH_A     = 8'h61;
   localparam char_type CH_C     = 8'h63;
   localparam char_type CH_D     = 8'h64;

   typedef enum logic [1:0] {
      OP_APPEND = 2'd0,
      OP_CHANGE = 2'd1,
      OP_DELETE = 2'd2,
      OP_BAD    = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      PH_LEAD1 = 4'd0,
      PH_NUM1  = 4'd1,
      PH_AFT1  = 4'd2,
      PH_COM1  = 4'd3,
      PH_NUM1B = 4'd4,
      PH_LET   = 4'd5,
      PH_LEAD2 = 4'd6,
      PH_NUM2  = 4'd7,
      PH_AFT2  = 4'd8,
      PH_COM2  = 4'd9,
      PH_NUM2B = 4'd10,
      PH_DONE  = 4'd11,
      PH_ERR   = 4'd12
   } phase_type;

   // Low OUT_WIDTH bits of a line number, zero extended when narrower.
   function automatic out_num_type to_out(input num_type value);
      logic [63:0] wide;
      wide = 64'(value);
      return wide[OUT_WIDTH-1:0];
   endfunction

endpackage

/* rtl/dccp_if.sv */
// ----------------------------------------------------------------------------
// dccp_if
// Valid/ready channels of the change command parser: one for command
// characters and one for parsed commands.
// ----------------------------------------------------------------------------
interface dccp_req_if import dccp_pkg::*; ();
   logic     valid;
   logic     ready;
   char_type ch;
   logic     line_end;

   modport source (output valid, output ch, output line_end, input ready);
   modport sink   (input valid, input ch, input line_end, output ready);
endinterface

interface dccp_rsp_if import dccp_pkg::*; ();
   logic        valid;
   logic        ready;
   logic [1:0]  op_code;
   out_num_type from_first;
   out_num_type from_last;
   out_num_type to_first;
   out_num_type to_last;
   logic        overflow;

   modport source (output valid, output op_code, output from_first, output from_last,
                   output to_first, output to_last, output overflow, input ready);
   modport sink   (input valid, input op_code, input from_first, input from_last,
                   input to_first, input to_last, input overflow, output ready);
endinterface

/* rtl/diff_change_command_parser.sv */
// A line end item passes through the character register and then the result
// register, which holds its result until the result is taken.
// Throughput: one item per cycle. Characters keep flowing while a result
// waits; a line end that reaches a full result register waits in the
// character register and holds off input until the result is taken.
// Reset: synchronous, active high; it empties both registers and returns the
// parser to the start of a line.
// ----------------------------------------------------------------------------
// diff_change_command_parser
// Parses one normal-format diff change command ("first[,last]{a|c|d}
// first[,last]") one character per item and emits one parsed command per
// line end item.
// ----------------------------------------------------------------------------
module diff_change_command_parser import dccp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   dccp_req_if.sink   req_ch,
   dccp_rsp_if.source rsp_ch
);

   // The accepted item first lands in a character register. From there it
   // updates the parser state as it leaves that register. A character always moves
   // on; a line end item moves on only when the result register is free or
   // is being emptied in the same cycle.
   logic     in_valid_ff, in_valid_in;
   char_type in_ch_ff;
   logic     in_le_ff;

   logic     rsp_valid_ff, rsp_valid_in;
   op_type      rsp_op_ff, rsp_op_in;
   out_num_type rsp_from_first_ff, rsp_from_first_in;
   out_num_type rsp_from_last_ff, rsp_from_last_in;
   out_num_type rsp_to_first_ff, rsp_to_first_in;
   out_num_type rsp_to_last_ff, rsp_to_last_in;
   logic        rsp_overflow_ff, rsp_overflow_in;

   // Parser state.
   phase_type phase_ff, phase_in;
   num_type   acc_ff, acc_in;
   num_type   src_first_ff, src_first_in;
   num_type   src_last_ff, src_last_in;
   num_type   dst_first_ff, dst_first_in;
   op_type    op_ff, op_in;
   logic      sat_ff, sat_in;

   logic out_free;
   logic stage_fire;
   logic req_fire;

   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign stage_fire = in_valid_ff && (!in_le_ff || out_free);
   assign req_fire   = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !in_valid_ff || stage_fire;

   assign in_valid_in = req_fire || (in_valid_ff && !stage_fire);

   // Character classes of the byte in the character register.
   logic       is_blank, is_digit, is_comma, is_nul, is_letter;
   op_type     letter_op;
   logic [3:0] digit;
   num_type    digit_num;

   always_comb begin
      is_blank  = (in_ch_ff == CH_SPACE) || (in_ch_ff == CH_TAB);
      is_digit  = (in_ch_ff >= CH_ZERO) && (in_ch_ff <= CH_NINE);
      is_comma  = (in_ch_ff == CH_COMMA);
      is_nul    = (in_ch_ff == CH_NUL);
      digit     = in_ch_ff[3:0];
      digit_num = NUM_WIDTH'(digit);
      is_letter = 1'b1;
      case (in_ch_ff)
         CH_A:    letter_op = OP_APPEND;
         CH_C:    letter_op = OP_CHANGE;
         CH_D:    letter_op = OP_DELETE;
         default: begin
            letter_op = OP_BAD;
            is_letter = 1'b0;
         end
      endcase
   end

   // Multiply-by-ten and add the digit. The product is four bits wider than
   // the accumulator, so any carry into those bits means the value would
   // pass the maximum; it then sticks at all ones and flags the overflow.
   logic [NUM_WIDTH+3:0] acc_wide;
   logic [NUM_WIDTH+3:0] acc_times_ten;
   logic                 mac_sat;
   num_type              acc_mac;

   always_comb begin
      acc_wide      = {4'b0000, acc_ff};
      acc_times_ten = (acc_wide << 3) + (acc_wide << 1) + (NUM_WIDTH+4)'(digit);
      mac_sat       = (acc_times_ten[NUM_WIDTH+3:NUM_WIDTH] != 4'b0000);
      acc_mac       = mac_sat ? {NUM_WIDTH{1'b1}} : acc_times_ten[NUM_WIDTH-1:0];
   end

   // End of the command text, either a line end or a NUL byte. Only a line
   // that has at least its target number complete is accepted.
   phase_type fin_phase;
   num_type   fin_acc;
   num_type   fin_dst;

   always_comb begin
      fin_acc = acc_ff;
      fin_dst = dst_first_ff;
      case (phase_ff)
         PH_NUM2: begin
            fin_dst   = acc_ff;
            fin_phase = PH_DONE;
         end
         PH_AFT2: begin
            fin_acc   = dst_first_ff;
            fin_phase = PH_DONE;
         end
         PH_NUM2B, PH_DONE: fin_phase = PH_DONE;
         default: fin_phase = PH_ERR;
      endcase
   end

   // Next parser state and result.
   always_comb begin
      phase_in     = phase_ff;
      acc_in       = acc_ff;
      src_first_in = src_first_ff;
      src_last_in  = src_last_ff;
      dst_first_in = dst_first_ff;
      op_in        = op_ff;
      sat_in       = sat_ff;

      rsp_valid_in      = rsp_valid_ff && !rsp_ch.ready;
      rsp_op_in         = rsp_op_ff;
      rsp_from_first_in = rsp_from_first_ff;
      rsp_from_last_in  = rsp_from_last_ff;
      rsp_to_first_in   = rsp_to_first_ff;
      rsp_to_last_in    = rsp_to_last_ff;
      rsp_overflow_in   = rsp_overflow_ff;

      if (stage_fire) begin
         if (in_le_ff) begin
            // Emit the result of the line and get ready for the next one.
            rsp_valid_in = 1'b1;
            if (fin_phase == PH_DONE) begin
               rsp_op_in         = op_ff;
               rsp_from_first_in = to_out(src_first_ff);
               rsp_from_last_in  = to_out(src_last_ff);
               rsp_to_first_in   = to_out(fin_dst);
               rsp_to_last_in    = to_out(fin_acc);
               rsp_overflow_in   = sat_ff;
            end else begin
               rsp_op_in         = OP_BAD;
               rsp_from_first_in = '0;
               rsp_from_last_in  = '0;
               rsp_to_first_in   = '0;
               rsp_to_last_in    = '0;
               rsp_overflow_in   = 1'b0;
            end
            phase_in     = PH_LEAD1;
            acc_in       = '0;
            src_first_in = '0;
            src_last_in  = '0;
            dst_first_in = '0;
            op_in        = OP_BAD;
            sat_in       = 1'b0;
         end else if (is_nul) begin
            // A NUL byte closes the command early; later bytes are ignored.
            phase_in     = fin_phase;
            acc_in       = fin_acc;
            dst_first_in = fin_dst;
         end else begin
            case (phase_ff)
               PH_LEAD1: begin
                  if (is_digit) begin
                     acc_in   = digit_num;
                     phase_in = PH_NUM1;
                  end else if (!is_blank) begin
                     phase_in = PH_ERR;
                  end
               end
               PH_NUM1: begin
                  if (is_digit) begin
                     acc_in = acc_mac;
                     sat_in = sat_ff | mac_sat;
                  end else begin
                     src_first_in = acc_ff;
                     if (is_blank) begin
                        phase_in = PH_AFT1;
                     end else if (is_comma) begin
                        phase_in = PH_COM1;
                     end else if (is_letter) begin
                        src_last_in = acc_ff;
                        op_in       = letter_op;
                        phase_in    = PH_LEAD2;
                     end else begin
                        phase_in = PH_ERR;
                     end
                  end
               end
               PH_AFT1: begin
                  if (is_comma) begin
                     phase_in = PH_COM1;
                  end else if (is_letter) begin
                     src_last_in = src_first_ff;
                     op_in       = letter_op;
                     phase_in    = PH_LEAD2;
                  end else if (!is_blank) begin
                     phase_in = PH_ERR;
                  end
               end
               PH_COM1: begin
                  if (is_digit) begin
                     acc_in   = digit_num;
                     phase_in = PH_NUM1B;
                  end else begin
                     phase_in = PH_ERR;
                  end
               end
               PH_NUM1B: begin
                  if (is_digit) begin
                     acc_in = acc_mac;
                     sat_in = sat_ff | mac_sat;
                  end else begin
                     src_last_in = acc_ff;
                     if (is_blank) begin
                        phase_in = PH_LET;
                     end else if (is_letter) begin
                        op_in    = letter_op;
                        phase_in = PH_LEAD2;
                     end else begin
                        phase_in = PH_ERR;
                     end
                  end
               end
               PH_LET: begin
                  if (is_letter) begin
                     op_in    = letter_op;
                     phase_in = PH_LEAD2;
                  end else if (!is_blank) begin
                     phase_in = PH_ERR;
                  end
               end
               PH_LEAD2: begin
                  if (is_digit) begin
                     acc_in   = digit_num;
                     phase_in = PH_NUM2;
                  end else if (!is_blank) begin
                     phase_in = PH_ERR;
                  end
               end
               PH_NUM2: begin
                  if (is_digit) begin
                     acc_in = acc_mac;
                     sat_in = sat_ff | mac_sat;
                  end else begin
                     dst_first_in = acc_ff;
                     if (is_blank) begin
                        phase_in = PH_AFT2;
                     end else if (is_comma) begin
                        phase_in = PH_COM2;
                     end else begin
                        phase_in = PH_DONE;
                     end
                  end
               end
               PH_AFT2: begin
                  if (is_comma) begin
                     phase_in = PH_COM2;
                  end else if (!is_blank) begin
                     // Any other byte ends the command with a single target line.
                     acc_in   = dst_first_ff;
                     phase_in = PH_DONE;
                  end
               end
               PH_COM2: begin
                  if (is_digit) begin
                     acc_in   = digit_num;
                     phase_in = PH_NUM2B;
                  end else begin
                     phase_in = PH_ERR;
                  end
               end
               PH_NUM2B: begin
                  if (is_digit) begin
                     acc_in = acc_mac;
                     sat_in = sat_ff | mac_sat;
                  end else begin
                     phase_in = PH_DONE;
                  end
               end
               default: begin
                  // A finished or broken command ignores the rest of its line.
                  phase_in = phase_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_LEAD1;
         acc_ff       <= '0;
         src_first_ff <= '0;
         src_last_ff  <= '0;
         dst_first_ff <= '0;
         sat_ff       <= 1'b0;
         op_ff        <= OP_BAD;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         acc_ff       <= acc_in;
         src_first_ff <= src_first_in;
         src_last_ff  <= src_last_in;
         dst_first_ff <= dst_first_in;
         sat_ff       <= sat_in;
         op_ff        <= op_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_ch_ff <= req_ch.ch;
         in_le_ff <= req_ch.line_end;
      end
      rsp_op_ff         <= rsp_op_in;
      rsp_from_first_ff <= rsp_from_first_in;
      rsp_from_last_ff  <= rsp_from_last_in;
      rsp_to_first_ff   <= rsp_to_first_in;
      rsp_to_last_ff    <= rsp_to_last_in;
      rsp_overflow_ff   <= rsp_overflow_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.op_code    = rsp_op_ff;
   assign rsp_ch.from_first = rsp_from_first_ff;
   assign rsp_ch.from_last  = rsp_from_last_ff;
   assign rsp_ch.to_first   = rsp_to_first_ff;
   assign rsp_ch.to_last    = rsp_to_last_ff;
   assign rsp_ch.overflow   = rsp_overflow_ff;

endmodule

/* rtl/dccp_checker.sv */
// ----------------------------------------------------------------------------
// dccp_checker
// Port-level checks of the change command parser, bound to its top level.
// ----------------------------------------------------------------------------
module dccp_checker import dccp_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_line_end,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_op_code,
   input out_num_type rsp_from_first,
   input out_num_type rsp_from_last,
   input out_num_type rsp_to_first,
   input out_num_type rsp_to_last,
   input logic        rsp_overflow
);

   // Line ends taken in whose result has not yet been delivered.
   logic [1:0] pend_ff, pend_in;
   logic       le_take;
   logic       rsp_take;

   assign le_take  = req_valid && req_ready && req_line_end;
   assign rsp_take = rsp_valid && rsp_ready;

   always_comb begin
      pend_in = pend_ff + {1'b0, le_take} - {1'b0, rsp_take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 2'd0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_no_spurious_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pend_ff != 2'd0))
      else $error("result shown without a pending line end");

   a_bounded_pending: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3)
      else $error("more line ends pending than the design can hold");

   a_bad_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_op_code == OP_BAD)) |->
         (rsp_from_first == '0) && (rsp_from_last == '0) && (rsp_to_first == '0) &&
         (rsp_to_last == '0) && !rsp_overflow)
      else $error("bad format result carries nonzero fields");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         rsp_valid && $stable(rsp_op_code) && $stable(rsp_from_first) &&
         $stable(rsp_from_last) && $stable(rsp_to_first) && $stable(rsp_to_last) &&
         $stable(rsp_overflow))
      else $error("stalled result changed");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind diff_change_command_parser dccp_checker u_dccp_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .req_line_end   (req_ch.line_end),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_op_code    (rsp_ch.op_code),
   .rsp_from_first (rsp_ch.from_first),
   .rsp_from_last  (rsp_ch.from_last),
   .rsp_to_first   (rsp_ch.to_first),
   .rsp_to_last    (rsp_ch.to_last),
   .rsp_overflow   (rsp_ch.overflow)
);

/* tb/diff_change_command_parser_test.sv */
// ----------------------------------------------------------------------------
// diff_change_command_parser_test
// Feeds change command lines to the parser one character per item, predicts
// every parsed command in the testbench and checks each result item against
// the prediction, with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module diff_change_command_parser_test;
   timeunit 1ns;
   timeprecision 1ps;

   import dccp_pkg::*;

   // Upper bound on the run length, in clock cycles.
   localparam int CYCLE_LIMIT = 60000;
   // Least number of random items queued after the directed lines.
   localparam int RANDOM_ITEMS = 400;
   // Largest line number the parser can hold before it saturates.
   localparam logic [63:0] LINE_MAX = (64'd1 << NUM_WIDTH) - 64'd1;

   typedef struct {
      char_type ch;
      logic     line_end;
   } char_item_type;

   typedef struct {
      op_type      op;
      out_num_type from_first;
      out_num_type from_last;
      out_num_type to_first;
      out_num_type to_last;
      logic        overflow;
   } parsed_cmd_type;

   logic clock;
   logic reset;

   dccp_req_if req_bus ();
   dccp_rsp_if rsp_bus ();

   diff_change_command_parser u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   // Items waiting to be driven, and commands waiting to come out.
   char_item_type  pending_items[$];
   parsed_cmd_type expected_cmds[$];
   // Scratch buffer for the line under construction.
   char_type    line_buf[$];

   int error_count = 0;
   int cycle_count = 0;

   // Idle control of both channels. In burst mode a side never idles.
   int req_gap   = 0;
   int rsp_stall = 0;
   bit req_burst = 0;
   bit rsp_burst = 0;

   // ------------------------------------------------------------------------
   // Command predictor. It mirrors the parser's grammar state; line numbers
   // are kept 64 bits wide so that the saturation test never wraps.
   // ------------------------------------------------------------------------
   phase_type   cmd_phase;
   logic [63:0] line_acc;
   logic [63:0] src_first;
   logic [63:0] src_last;
   logic [63:0] dst_first;
   op_type      cmd_op;
   logic        cmd_sat;

   function void clear_command();
      cmd_phase = PH_LEAD1;
      line_acc  = '0;
      src_first = '0;
      src_last  = '0;
      dst_first = '0;
      cmd_op    = OP_BAD;
      cmd_sat   = 1'b0;
   endfunction

   // Adds one decimal digit to the running line number, holding it at the
   // maximum (and flagging the line) when the next value would not fit.
   function void add_digit(char_type c);
      logic [63:0] digit;
      digit = 64'(c - CH_ZERO);
      if (line_acc > (LINE_MAX - digit) / 64'd10) begin
         line_acc = LINE_MAX;
         cmd_sat  = 1'b1;
      end else begin
         line_acc = line_acc * 64'd10 + digit;
      end
   endfunction

   // The command text ends here, either at a line end or at a NUL byte.
   // Only a line that has its target number complete is well formed.
   function void end_of_text();
      case (cmd_phase)
         PH_NUM2: begin
            dst_first = line_acc;
            cmd_phase = PH_DONE;
         end
         PH_AFT2: begin
            line_acc  = dst_first;
            cmd_phase = PH_DONE;
         end
         PH_NUM2B, PH_DONE: cmd_phase = PH_DONE;
         default:           cmd_phase = PH_ERR;
      endcase
   endfunction

   function void take_char(char_type c);
      logic   blank;
      logic   digit;
      logic   letter;
      op_type letter_op;
      blank  = (c == CH_SPACE) || (c == CH_TAB);
      digit  = (c >= CH_ZERO) && (c <= CH_NINE);
      letter = 1'b1;
      case (c)
         CH_A:    letter_op = OP_APPEND;
         CH_C:    letter_op = OP_CHANGE;
         CH_D:    letter_op = OP_DELETE;
         default: begin
            letter    = 1'b0;
            letter_op = OP_BAD;
         end
      endcase
      if (c == CH_NUL) begin
         end_of_text();
      end else begin
         case (cmd_phase)
            PH_LEAD1: begin
               if (digit) begin
                  line_acc = '0;
                  add_digit(c);
                  cmd_phase = PH_NUM1;
               end else if (!blank) begin
                  cmd_phase = PH_ERR;
               end
            end
            PH_NUM1: begin
               if (digit) begin
                  add_digit(c);
               end else begin
                  src_first = line_acc;
                  if (blank) begin
                     cmd_phase = PH_AFT1;
                  end else if (c == CH_COMMA) begin
                     cmd_phase = PH_COM1;
                  end else if (letter) begin
                     src_last  = line_acc;
                     cmd_op    = letter_op;
                     cmd_phase = PH_LEAD2;
                  end else begin
                     cmd_phase = PH_ERR;
                  end
               end
            end
            PH_AFT1: begin
               if (c == CH_COMMA) begin
                  cmd_phase = PH_COM1;
               end else if (letter) begin
                  src_last  = src_first;
                  cmd_op    = letter_op;
                  cmd_phase = PH_LEAD2;
               end else if (!blank) begin
                  cmd_phase = PH_ERR;
               end
            end
            PH_COM1: begin
               if (digit) begin
                  line_acc = '0;
                  add_digit(c);
                  cmd_phase = PH_NUM1B;
               end else begin
                  cmd_phase = PH_ERR;
               end
            end
            PH_NUM1B: begin
               if (digit) begin
                  add_digit(c);
               end else begin
                  src_last = line_acc;
                  if (blank) begin
                     cmd_phase = PH_LET;
                  end else if (letter) begin
                     cmd_op    = letter_op;
                     cmd_phase = PH_LEAD2;
                  end else begin
                     cmd_phase = PH_ERR;
                  end
               end
            end
            PH_LET: begin
               if (letter) begin
                  cmd_op    = letter_op;
                  cmd_phase = PH_LEAD2;
               end else if (!blank) begin
                  cmd_phase = PH_ERR;
               end
            end
            PH_LEAD2: begin
               if (digit) begin
                  line_acc = '0;
                  add_digit(c);
                  cmd_phase = PH_NUM2;
               end else if (!blank) begin
                  cmd_phase = PH_ERR;
               end
            end
            PH_NUM2: begin
               if (digit) begin
                  add_digit(c);
               end else begin
                  dst_first = line_acc;
                  if (blank) begin
                     cmd_phase = PH_AFT2;
                  end else if (c == CH_COMMA) begin
                     cmd_phase = PH_COM2;
                  end else begin
                     cmd_phase = PH_DONE;
                  end
               end
            end
            PH_AFT2: begin
               if (c == CH_COMMA) begin
                  cmd_phase = PH_COM2;
               end else if (!blank) begin
                  line_acc  = dst_first;
                  cmd_phase = PH_DONE;
               end
            end
            PH_COM2: begin
               if (digit) begin
                  line_acc = '0;
                  add_digit(c);
                  cmd_phase = PH_NUM2B;
               end else begin
                  cmd_phase = PH_ERR;
               end
            end
            PH_NUM2B: begin
               if (digit) begin
                  add_digit(c);
               end else begin
                  cmd_phase = PH_DONE;
               end
            end
            // A finished or broken line ignores everything up to its end.
            default: ;
         endcase
      end
   endfunction

   // Called for every accepted input item. A line end closes the command
   // and queues the parsed command that the parser must produce for it.
   function void predict_item(char_type c, logic line_end);
      parsed_cmd_type cmd;
      if (!line_end) begin
         take_char(c);
      end else begin
         end_of_text();
         if (cmd_phase == PH_DONE) begin
            cmd.op         = cmd_op;
            cmd.from_first = out_num_type'(src_first);
            cmd.from_last  = out_num_type'(src_last);
            cmd.to_first   = out_num_type'(dst_first);
            cmd.to_last    = out_num_type'(line_acc);
            cmd.overflow   = cmd_sat;
         end else begin
            // A bad line reports nothing but the bad format code.
            cmd.op         = OP_BAD;
            cmd.from_first = '0;
            cmd.from_last  = '0;
            cmd.to_first   = '0;
            cmd.to_last    = '0;
            cmd.overflow   = 1'b0;
         end
         expected_cmds.insert(expected_cmds.size(), cmd);
         clear_command();
      end
   endfunction

   // ------------------------------------------------------------------------
   // Clock and reset. Reset is held only at the start of the run.
   // ------------------------------------------------------------------------
   initial clock = 1'b0;
   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t ns: timeout after %0d cycles", $time, cycle_count);
         $display("diff_change_command_parser_test: done, errors");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Character driver. Items are separated by random idle gaps, except in
   // burst stretches where items follow back to back.
   // Every accepted item goes through the predictor right away.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : drive_chars
      char_item_type next_item;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_item(req_bus.ch, req_bus.line_end);
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_bus.valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               next_item = pending_items.pop_front();
               req_bus.valid    <= 1'b1;
               req_bus.ch       <= next_item.ch;
               req_bus.line_end <= next_item.line_end;
               if ($urandom_range(0, 39) == 0) begin
                  req_burst = !req_burst;
               end
               req_gap = req_burst ? 0 : $urandom_range(0, 4);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result monitor. Each accepted result item is compared field by field
   // with the oldest predicted command; ready then drops for a random
   // number of cycles before the next result may be taken.
   // ------------------------------------------------------------------------
   function void compare_field(string name, logic [31:0] expected, logic [31:0] actual);
      if (actual !== expected) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                  $time, name, expected, actual);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin : watch_results
      parsed_cmd_type cmd;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_cmds.size() == 0) begin
               $display("%0t ns: result item with none expected, op_code %0d",
                        $time, rsp_bus.op_code);
               error_count++;
            end else begin
               cmd = expected_cmds.pop_front();
               compare_field("op_code",    32'(cmd.op),       32'(rsp_bus.op_code));
               compare_field("from_first", cmd.from_first,    rsp_bus.from_first);
               compare_field("from_last",  cmd.from_last,     rsp_bus.from_last);
               compare_field("to_first",   cmd.to_first,      rsp_bus.to_first);
               compare_field("to_last",    cmd.to_last,       rsp_bus.to_last);
               compare_field("overflow",   32'(cmd.overflow), 32'(rsp_bus.overflow));
            end
            if ($urandom_range(0, 19) == 0) begin
               rsp_burst = !rsp_burst;
            end
            rsp_stall = rsp_burst ? 0 : $urandom_range(0, 4);
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------------
   function void push_item(char_type c, logic line_end);
      char_item_type item;
      item.ch       = c;
      item.line_end = line_end;
      pending_items.insert(pending_items.size(), item);
   endfunction

   // The character field of a line end item is don't care, so it is random.
   function void push_line_end();
      push_item(char_type'($urandom_range(0, 255)), 1'b1);
   endfunction

   function void push_text(string s);
      for (int i = 0; i < s.len(); i++) begin
         push_item(char_type'(s[i]), 1'b0);
      end
   endfunction

   function void add_blanks();
      int count;
      count = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
      for (int i = 0; i < count; i++) begin
         line_buf.insert(line_buf.size(), $urandom_range(0, 1) ? CH_SPACE : CH_TAB);
      end
   endfunction

   // Mostly short numbers; now and then nine to twelve digits so that
   // values near and past the saturation point turn up.
   function void add_number();
      int count;
      count = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 4);
      for (int i = 0; i < count; i++) begin
         line_buf.insert(line_buf.size(), char_type'(CH_ZERO + $urandom_range(0, 9)));
      end
   endfunction

   function void add_letter();
      case ($urandom_range(0, 2))
         0:       line_buf.insert(line_buf.size(), CH_A);
         1:       line_buf.insert(line_buf.size(), CH_C);
         default: line_buf.insert(line_buf.size(), CH_D);
      endcase
   endfunction

   // Builds one well formed command with random content, then sometimes
   // breaks it: a stray byte, a cut, an embedded NUL, or pure noise.
   function void build_line();
      int pos;
      line_buf.delete();
      add_blanks();
      add_number();
      if ($urandom_range(0, 1)) begin
         line_buf.insert(line_buf.size(), CH_COMMA);
         add_number();
      end
      add_blanks();
      add_letter();
      add_blanks();
      add_number();
      if ($urandom_range(0, 1)) begin
         add_blanks();
         line_buf.insert(line_buf.size(), CH_COMMA);
         add_number();
      end
      if ($urandom_range(0, 3) == 0) begin
         for (int i = $urandom_range(1, 3); i > 0; i--) begin
            line_buf.insert(line_buf.size(), char_type'($urandom_range(0, 255)));
         end
      end
      case ($urandom_range(0, 9))
         0: begin
            pos = $urandom_range(0, line_buf.size() - 1);
            line_buf[pos] = char_type'($urandom_range(0, 255));
         end
         1: begin
            pos = $urandom_range(0, line_buf.size() - 1);
            while (line_buf.size() > pos) begin
               void'(line_buf.pop_back());
            end
         end
         2: begin
            pos = $urandom_range(0, line_buf.size());
            line_buf.insert(pos, CH_NUL);
         end
         3: begin
            line_buf.delete();
            for (int i = $urandom_range(0, 6); i > 0; i--) begin
               line_buf.insert(line_buf.size(), char_type'($urandom_range(0, 255)));
            end
         end
         default: ;
      endcase
      foreach (line_buf[i]) begin
         push_item(line_buf[i], 1'b0);
      end
      push_line_end();
   endfunction

   // ------------------------------------------------------------------------
   // Test sequence.
   // ------------------------------------------------------------------------
   initial begin
      int random_start;
      int settle;

      req_bus.valid    = 1'b0;
      req_bus.ch       = '0;
      req_bus.line_end = 1'b0;
      rsp_bus.ready    = 1'b0;
      reset            = 1'b1;
      clear_command();

      // Directed lines: each operation, both range forms with blanks,
      // saturation, a blank after a comma, a trailing comma, a NUL that
      // ends the command early, a stray top byte, an empty line, ignored
      // text after a complete command, and an upper-case letter.
      push_text("1a2");
      push_line_end();
      push_text("\t3,4c 5 ,6");
      push_line_end();
      push_text("4294967296d0");
      push_line_end();
      push_text("1, 2a3");
      push_line_end();
      push_text("7c8,");
      push_line_end();
      push_text("2d3");
      push_item(CH_NUL, 1'b0);
      push_item(8'hFF, 1'b0);
      push_line_end();
      push_item(8'hFF, 1'b0);
      push_line_end();
      push_line_end();
      push_text("9a1 xQ");
      push_line_end();
      push_text("5C6");
      push_line_end();

      random_start = pending_items.size();
      while (pending_items.size() < random_start + RANDOM_ITEMS) begin
         build_line();
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Wait for every item to be taken and every command to come out.
      while (pending_items.size() > 0 || req_bus.valid) begin
         @(posedge clock);
      end
      while (expected_cmds.size() > 0) begin
         @(posedge clock);
      end
      // Keep clocking so that a spurious late result is still caught.
      for (settle = 0; settle < 12; settle++) begin
         @(posedge clock);
      end

      if (error_count == 0) begin
         $display("diff_change_command_parser_test: done, clean");
      end else begin
         $display("diff_change_command_parser_test: done, errors");
      end
      $finish;
   end

endmodule
